### hw/rtl/http_chunked_body_decoder_macros.svh
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_macros.svh
// Assertion macros used by the checker hcbd_chk. Each expects clk and rst_n
// in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, character codes and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // width of the chunk size / remaining byte counter
  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_LOW_A   = 8'd97;
  localparam logic [7:0] CH_LOW_F   = 8'd102;
  localparam logic [7:0] CH_UP_A    = 8'd65;
  localparam logic [7:0] CH_UP_F    = 8'd70;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [4:0] HEX_TEN    = 5'd10;
  localparam logic [4:0] HEX_NONE   = 5'd16;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_SIZE_LF,
    PH_DATA,
    PH_TRAIL_CR,
    PH_TRAIL_LF
  } phase_t;

  typedef enum logic [1:0] {
    ST_COMPLETE,
    ST_MALFORMED,
    ST_TRUNCATED
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_is_data;
    logic       out_end;
    status_t    end_status;
  } out_item_t;

  // input register contents
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } stage_t;

  // result of one byte, handed to the result register
  typedef struct packed {
    logic      has;
    out_item_t item;
  } res_t;

  // 0..15 for a hex digit, HEX_NONE otherwise
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 5'(c - CH_ZERO);
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      v = 5'(c - CH_LOW_A) + HEX_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = 5'(c - CH_UP_A) + HEX_TEN;
    end
    return v;
  endfunction

endpackage

### hw/rtl/hcbd_in_reg.sv
// ----------------------------------------------------------------------------
// hcbd_in_reg
// Input register: holds one beat until the decode stage moves it on.
// ----------------------------------------------------------------------------
module hcbd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hcbd_pkg::in_item_t in_data,
  input  logic              advance,
  output hcbd_pkg::stage_t  stage
);

  logic               vld_r;
  logic               vld_nxt;
  hcbd_pkg::in_item_t item_r;

  // free when empty or when the held beat leaves this cycle
  assign in_stall = vld_r && !advance;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

### hw/rtl/hcbd_parse.sv
// ----------------------------------------------------------------------------
// hcbd_parse
// Framing state machine: size digits, CR LF, payload count, trailing CR LF.
// ----------------------------------------------------------------------------
module hcbd_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  hcbd_pkg::stage_t stage,
  input  logic             take,
  output logic             advance,
  output hcbd_pkg::res_t   res
);

  hcbd_pkg::phase_t                phase_r;
  hcbd_pkg::phase_t                phase_nxt;
  logic [hcbd_pkg::SIZE_BITS-1:0]  count_r;
  logic [hcbd_pkg::SIZE_BITS-1:0]  count_nxt;
  logic                            done_r;
  logic                            done_nxt;
  logic                            is_data;
  logic                            ended;
  hcbd_pkg::status_t               status;
  logic [4:0]                      hv;
  logic [7:0]                      b;

  assign b  = stage.item.in_byte;
  assign hv = hcbd_pkg::hex_decode(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcbd_pkg::PH_SIZE;
      count_r <= '0;
      done_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    is_data   = 1'b0;
    ended     = 1'b0;
    status    = hcbd_pkg::ST_COMPLETE;
    if (!done_r) begin
      case (phase_r)
        hcbd_pkg::PH_SIZE: begin
          if (!hv[4]) begin
            // a digit with the top nibble already in use overflows
            if (count_r[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
              ended  = 1'b1;
              status = hcbd_pkg::ST_MALFORMED;
            end else begin
              count_nxt = {count_r[hcbd_pkg::SIZE_BITS-5:0], hv[3:0]};
            end
          end else if (b == hcbd_pkg::CH_CR) begin
            phase_nxt = hcbd_pkg::PH_SIZE_LF;
          end else begin
            ended  = 1'b1;
            status = hcbd_pkg::ST_MALFORMED;
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (b != hcbd_pkg::CH_LF) begin
            ended  = 1'b1;
            status = hcbd_pkg::ST_MALFORMED;
          end else if (count_r == '0) begin
            ended  = 1'b1;
            status = hcbd_pkg::ST_COMPLETE;
          end else begin
            phase_nxt = hcbd_pkg::PH_DATA;
          end
        end
        hcbd_pkg::PH_DATA: begin
          is_data   = 1'b1;
          count_nxt = count_r - hcbd_pkg::SIZE_BITS'(1);
          if (count_nxt == '0) begin
            phase_nxt = hcbd_pkg::PH_TRAIL_CR;
          end
        end
        hcbd_pkg::PH_TRAIL_CR: begin
          if (b == hcbd_pkg::CH_CR) begin
            phase_nxt = hcbd_pkg::PH_TRAIL_LF;
          end else begin
            ended  = 1'b1;
            status = hcbd_pkg::ST_MALFORMED;
          end
        end
        hcbd_pkg::PH_TRAIL_LF: begin
          if (b == hcbd_pkg::CH_LF) begin
            phase_nxt = hcbd_pkg::PH_SIZE;
            count_nxt = '0;
          end else begin
            ended  = 1'b1;
            status = hcbd_pkg::ST_MALFORMED;
          end
        end
        default: begin
          ended  = 1'b1;
          status = hcbd_pkg::ST_MALFORMED;
        end
      endcase
      // buffer ran out before the zero chunk
      if (!ended && stage.item.in_final) begin
        ended  = 1'b1;
        status = hcbd_pkg::ST_TRUNCATED;
      end
    end
    done_nxt = done_r || ended;

    res.has              = stage.vld && (is_data || ended);
    res.item.out_byte    = is_data ? b : 8'd0;
    res.item.out_is_data = is_data;
    res.item.out_end     = ended;
    res.item.end_status  = ended ? status : hcbd_pkg::ST_COMPLETE;

    advance = stage.vld && (!(is_data || ended) || take);
  end

endmodule

### hw/rtl/hcbd_out_reg.sv
// ----------------------------------------------------------------------------
// hcbd_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module hcbd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  hcbd_pkg::res_t      res,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbd_pkg::out_item_t out_data
);

  logic                vld_r;
  logic                vld_nxt;
  hcbd_pkg::out_item_t item_r;

  assign take    = !vld_r || !out_stall;
  assign vld_nxt = take ? res.has : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.has) begin
      item_r <= res.item;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = item_r;

endmodule

### hw/rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked body one byte per beat into payload bytes and
// one end beat with a status.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  in_data  : in_byte, in_final
//   out_     out  out_valid/out_stall out_data : out_byte, out_is_data,
//                                               out_end, end_status
//
// One input beat per cycle while in_stall is low; a result passes through the
// input register, decode and the result register on its way out.
// Each beat gives zero or one result; beats after the end give none.
// Reset is synchronous and clears framing state, counter and end flag.
// out_stall backs up into in_stall only while a beat that has a result
// waits on a full result register.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbd_pkg::out_item_t out_data
);

  hcbd_pkg::stage_t stage;
  hcbd_pkg::res_t   res;
  logic             advance;
  logic             take;

  hcbd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  hcbd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .take    (take),
    .advance (advance),
    .res     (res)
  );

  hcbd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/hcbd_chk.sv
// ----------------------------------------------------------------------------
// hcbd_chk
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_macros.svh"

module hcbd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hcbd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input hcbd_pkg::out_item_t out_data
);

  logic ended_r;

  // set once the end beat has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
    end else if (out_valid && !out_stall && out_data.out_end) begin
      ended_r <= 1'b1;
    end
  end

  `HCBD_ASSERT_NOW(a_in_known, in_valid && !in_stall, !$isunknown(in_data), "unknown beat")
  `HCBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped")
  `HCBD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "payload moved")
  `HCBD_ASSERT_NOW(a_no_empty, out_valid, out_data.out_is_data || out_data.out_end, "empty")
  `HCBD_ASSERT_NOW(a_quiet_after_end, ended_r, !out_valid, "result beat after the end beat")

endmodule

bind http_chunked_body_decoder hcbd_chk u_hcbd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/http_chunked_body_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_test
// Feeds one long chunked body through the decoder: a short directed table,
// then random chunks of random size and content, then one randomly chosen
// ending (zero chunk, empty size line, bad framing, size overflow or
// truncation on the final byte), then bytes after the end that must be
// dropped. Each result beat is checked against the table or a cycle-free framing
// model, with random gaps on the sender and random stall on the receiver.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_test;

  localparam int BODY_BEATS   = 1850;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_LEN      = 18;

  typedef struct packed {
    hcbd_pkg::in_item_t  beat;
    logic                fixed;
    logic                has;
    hcbd_pkg::out_item_t want;
  } dir_row_t;

  localparam hcbd_pkg::out_item_t NO_RESULT = '0;

  // directed body: "02" CR LF 00 FF CR LF "003" CR LF 0D 0A 80 CR LF
  localparam dir_row_t DIR_TABLE [DIR_LEN] = '{
    '{'{hcbd_pkg::CH_ZERO, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_ZERO + 8'd2, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_CR, 1'b0}, 1'b1, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_LF, 1'b0}, 1'b1, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, hcbd_pkg::ST_COMPLETE}},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, hcbd_pkg::ST_COMPLETE}},
    '{'{hcbd_pkg::CH_CR, 1'b0}, 1'b1, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_LF, 1'b0}, 1'b1, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_ZERO, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_ZERO, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_ZERO + 8'd3, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_CR, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_LF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_CR, 1'b0}, 1'b1, 1'b1,
      '{hcbd_pkg::CH_CR, 1'b1, 1'b0, hcbd_pkg::ST_COMPLETE}},
    '{'{hcbd_pkg::CH_LF, 1'b0}, 1'b1, 1'b1,
      '{hcbd_pkg::CH_LF, 1'b1, 1'b0, hcbd_pkg::ST_COMPLETE}},
    '{'{8'h80, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_CR, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{'{hcbd_pkg::CH_LF, 1'b0}, 1'b0, 1'b0, NO_RESULT}
  };

  typedef enum int {
    END_ZERO_CHUNK,
    END_EMPTY_LINE,
    END_ZERO_FINAL_LF,
    END_BAD_SIZE_CHAR,
    END_BAD_SIZE_LF,
    END_BAD_TRAIL_CR,
    END_BAD_TRAIL_LF,
    END_SIZE_OVERFLOW,
    END_TRUNC_PAYLOAD,
    END_TRUNC_SIZE,
    END_TRUNC_TRAIL,
    END_BAD_FINAL,
    END_KINDS
  } body_end_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hcbd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hcbd_pkg::out_item_t out_data;

  // framing model state
  hcbd_pkg::phase_t               frame_phase;
  logic [hcbd_pkg::SIZE_BITS-1:0] frame_count;
  logic                           body_over;

  hcbd_pkg::out_item_t results_due[$];
  int                  mismatches;
  int                  body_beats;
  int                  idle_cycles;
  logic                steady;

  http_chunked_body_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] v;
    v = hcbd_pkg::HEX_NONE;
    if (c >= hcbd_pkg::CH_ZERO && c <= hcbd_pkg::CH_NINE) v = {1'b0, c[3:0]};
    else if ((c >= hcbd_pkg::CH_LOW_A && c <= hcbd_pkg::CH_LOW_F) ||
             (c >= hcbd_pkg::CH_UP_A && c <= hcbd_pkg::CH_UP_F))
      v = 5'(c[2:0]) + 5'd9;
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned v);
    logic [7:0] c;
    if (v < 10) c = hcbd_pkg::CH_ZERO + 8'(v);
    else c = ($urandom_range(0, 1) ? hcbd_pkg::CH_UP_A : hcbd_pkg::CH_LOW_A)
             + 8'(v - 10);
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // one byte through the framing model
  task automatic decode_byte(input hcbd_pkg::in_item_t b, output logic has,
                             output hcbd_pkg::out_item_t res);
    logic [4:0]        nib;
    logic              data_beat;
    logic              ended;
    hcbd_pkg::status_t st;
    data_beat = 1'b0;
    ended     = 1'b0;
    st        = hcbd_pkg::ST_COMPLETE;
    has       = 1'b0;
    res       = '0;
    if (!body_over) begin
      case (frame_phase)
        hcbd_pkg::PH_SIZE: begin
          nib = nibble_of(b.in_byte);
          if (nib != hcbd_pkg::HEX_NONE) begin
            if (frame_count[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
              ended = 1'b1;
              st    = hcbd_pkg::ST_MALFORMED;
            end else begin
              frame_count = {frame_count[hcbd_pkg::SIZE_BITS-5:0], nib[3:0]};
            end
          end else if (b.in_byte == hcbd_pkg::CH_CR) begin
            frame_phase = hcbd_pkg::PH_SIZE_LF;
          end else begin
            ended = 1'b1;
            st    = hcbd_pkg::ST_MALFORMED;
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (b.in_byte != hcbd_pkg::CH_LF) begin
            ended = 1'b1;
            st    = hcbd_pkg::ST_MALFORMED;
          end else if (frame_count == '0) begin
            ended = 1'b1;
          end else begin
            frame_phase = hcbd_pkg::PH_DATA;
          end
        end
        hcbd_pkg::PH_DATA: begin
          data_beat   = 1'b1;
          frame_count = frame_count - 1'b1;
          if (frame_count == '0) frame_phase = hcbd_pkg::PH_TRAIL_CR;
        end
        hcbd_pkg::PH_TRAIL_CR: begin
          if (b.in_byte == hcbd_pkg::CH_CR) begin
            frame_phase = hcbd_pkg::PH_TRAIL_LF;
          end else begin
            ended = 1'b1;
            st    = hcbd_pkg::ST_MALFORMED;
          end
        end
        hcbd_pkg::PH_TRAIL_LF: begin
          if (b.in_byte == hcbd_pkg::CH_LF) begin
            frame_phase = hcbd_pkg::PH_SIZE;
            frame_count = '0;
          end else begin
            ended = 1'b1;
            st    = hcbd_pkg::ST_MALFORMED;
          end
        end
        default: begin
          ended = 1'b1;
          st    = hcbd_pkg::ST_MALFORMED;
        end
      endcase
      if (!ended && b.in_final) begin
        ended = 1'b1;
        st    = hcbd_pkg::ST_TRUNCATED;
      end
      if (ended) body_over = 1'b1;
      has             = data_beat | ended;
      res.out_byte    = data_beat ? b.in_byte : 8'h00;
      res.out_is_data = data_beat;
      res.out_end     = ended;
      res.end_status  = ended ? st : hcbd_pkg::ST_COMPLETE;
    end
  endtask

  task automatic send_beat(input hcbd_pkg::in_item_t b, input logic fixed,
                           input logic fixed_has, input hcbd_pkg::out_item_t fixed_want);
    int                  gap;
    logic                has;
    hcbd_pkg::out_item_t res;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!body_over) body_beats++;
    decode_byte(b, has, res);
    if (fixed) begin
      has = fixed_has;
      res = fixed_want;
    end
    if (has) results_due.push_back(res);
  endtask

  task automatic send_raw(input logic [7:0] b, input logic fin);
    send_beat('{b, fin}, 1'b0, 1'b0, NO_RESULT);
  endtask

  task automatic send_size_digits(input int unsigned n);
    int nd;
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    repeat ($urandom_range(0, 2)) send_raw(hcbd_pkg::CH_ZERO, 1'b0);
    for (int i = nd - 1; i >= 0; i--) send_raw(hex_char((n >> (4 * i)) & 15), 1'b0);
  endtask

  task automatic send_payload(input int unsigned n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) send_raw(hcbd_pkg::CH_CR, 1'b0);
      else if (r == 1) send_raw(hcbd_pkg::CH_LF, 1'b0);
      else send_raw(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic send_chunk(input int unsigned n);
    send_size_digits(n);
    send_raw(hcbd_pkg::CH_CR, 1'b0);
    send_raw(hcbd_pkg::CH_LF, 1'b0);
    send_payload(n);
    send_raw(hcbd_pkg::CH_CR, 1'b0);
    send_raw(hcbd_pkg::CH_LF, 1'b0);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] byte_not_size();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (nibble_of(b) != hcbd_pkg::HEX_NONE || b == hcbd_pkg::CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] ch);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ch);
    return b;
  endfunction

  task automatic send_ending(input body_end_t kind);
    int unsigned n;
    n = $urandom_range(1, 8);
    case (kind)
      END_ZERO_CHUNK: begin
        send_size_digits(0);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b0);
      end
      END_EMPTY_LINE: begin
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b0);
      end
      END_ZERO_FINAL_LF: begin
        send_raw(hcbd_pkg::CH_ZERO, 1'b0);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b1);
      end
      END_BAD_SIZE_CHAR: begin
        send_size_digits(n);
        send_raw(byte_not_size(), 1'b0);
      end
      END_BAD_SIZE_LF: begin
        send_size_digits(n);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(byte_other_than(hcbd_pkg::CH_LF), 1'b0);
      end
      END_BAD_TRAIL_CR: begin
        send_size_digits(n);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b0);
        send_payload(n);
        send_raw(byte_other_than(hcbd_pkg::CH_CR), 1'b0);
      end
      END_BAD_TRAIL_LF: begin
        send_size_digits(n);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b0);
        send_payload(n);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(byte_other_than(hcbd_pkg::CH_LF), 1'b0);
      end
      END_SIZE_OVERFLOW: begin
        // eight digits with a nonzero lead fill the counter, the ninth overflows
        send_raw(hex_char($urandom_range(1, 15)), 1'b0);
        repeat (7) send_raw(hex_char($urandom_range(0, 15)), 1'b0);
        send_raw(hex_char($urandom_range(0, 15)), 1'b0);
      end
      END_TRUNC_PAYLOAD: begin
        send_size_digits(n);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b0);
        send_payload($urandom_range(0, n - 1));
        send_raw(8'($urandom_range(0, 255)), 1'b1);
      end
      END_TRUNC_SIZE: begin
        send_raw(hex_char($urandom_range(1, 15)), 1'b0);
        if ($urandom_range(0, 1)) send_raw(hex_char($urandom_range(0, 15)), 1'b1);
        else send_raw(hcbd_pkg::CH_CR, 1'b1);
      end
      END_TRUNC_TRAIL: begin
        send_size_digits(n);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b0);
        send_payload(n);
        send_raw(hcbd_pkg::CH_CR, 1'b0);
        send_raw(hcbd_pkg::CH_LF, 1'b1);
      end
      default: begin
        // malformed byte that is also the final one
        send_size_digits(n);
        send_raw(byte_not_size(), 1'b1);
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input hcbd_pkg::out_item_t want,
                               input hcbd_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch (%s): want %02h %b %b %0d, got %02h %b %b %0d",
               $realtime, what, want.out_byte, want.out_is_data, want.out_end,
               want.end_status, got.out_byte, got.out_is_data, got.out_end,
               got.end_status);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    hcbd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected beat", NO_RESULT, out_data);
      end else begin
        want = results_due.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.out_is_data !== want.out_is_data ||
            out_data.out_end !== want.out_end ||
            out_data.end_status !== want.end_status)
          flag_mismatch("field", want, out_data);
      end
    end
  end

  // no beat on either side for too long ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin : drive_stall
    int lo;
    int hi;
    wait (rst_n === 1'b1);
    forever begin
      lo = ($urandom_range(0, 11) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      hi = pick_gap();
      out_stall <= 1'b0;
      repeat (lo) @(posedge clk);
      if (hi > 0) begin
        out_stall <= 1'b1;
        repeat (hi) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    frame_phase = hcbd_pkg::PH_SIZE;
    frame_count = '0;
    body_over   = 1'b0;
    mismatches  = 0;
    body_beats  = 0;
    idle_cycles = 0;
    steady      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_LEN; i++)
      send_beat(DIR_TABLE[i].beat, DIR_TABLE[i].fixed, DIR_TABLE[i].has, DIR_TABLE[i].want);
    hold_until_drained();

    while (body_beats < BODY_BEATS) begin
      steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 39) == 0) hold_until_drained();
      case ($urandom_range(0, 19))
        0: send_chunk($urandom_range(65, 300));
        1, 2, 3, 4, 5: send_chunk($urandom_range(17, 64));
        default: send_chunk($urandom_range(1, 16));
      endcase
    end
    steady = 1'b0;
    send_ending(body_end_t'($urandom_range(0, END_KINDS - 1)));

    // everything after the end beat must be dropped
    send_raw(8'($urandom_range(0, 255)), 1'b1);
    send_raw(8'($urandom_range(0, 255)), 1'b0);
    repeat ($urandom_range(16, 40))
      send_raw(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
